// ===== sv/tie_pkg.sv =====
// Shared types and constants for the triangle isoline extractor.
// No dependencies; imported by every module of the block.
package tie_pkg;

    localparam int MAX_LEVELS = 16;
    localparam int RESULT_CAP = 16;
    localparam int EFF_MAX    = (MAX_LEVELS < RESULT_CAP) ? MAX_LEVELS : RESULT_CAP;
    localparam int IDX_W      = $clog2(EFF_MAX);
    localparam int CNT_W      = 5;
    localparam int DATA_W     = 32;
    localparam int T_FRAC     = 24;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = T_FRAC / DIV_STEPS;
    localparam int CROSS_LAT  = DIV_STAGES + 3;
    localparam int STEP_ITERS = DATA_W + 1;
    localparam int TRI_W      = 9 * DATA_W;
    localparam int OUT_W      = ((4 * DATA_W + IDX_W + 7) / 8) * 8;

    localparam logic [1:0] CFG_LEVEL_MIN   = 2'd0;
    localparam logic [1:0] CFG_LEVEL_MAX   = 2'd1;
    localparam logic [1:0] CFG_LEVEL_COUNT = 2'd2;

    typedef logic signed [DATA_W-1:0] q_t;

    typedef struct packed {
        logic             valid;
        logic             marker;
        logic [IDX_W-1:0] idx;
    } issue_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_STEP  = 3'b010,
        ST_SWEEP = 3'b100
    } seq_state_t;

endpackage

// ===== sv/tie_seq.sv =====
// Configuration registers, step divider and level sequencer.
// Depends on tie_pkg.
module tie_seq
    import tie_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wen,
    input  logic [1:0]        cfg_index,
    input  logic [DATA_W-1:0] cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [TRI_W-1:0]  in_tri,
    input  logic              en,
    output issue_t            issue,
    output logic [TRI_W-1:0]  tri_data,
    output q_t                level_min,
    output q_t                step
);

    seq_state_t        state_reg, state_next;
    q_t                min_reg, min_next, max_reg, max_next, step_reg, step_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              step_valid_reg, step_valid_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              marker_reg, marker_next;
    logic [TRI_W-1:0]  tri_reg, tri_next;
    logic [3:0]        rem_reg, rem_next;
    logic [DATA_W:0]   quo_reg, quo_next;
    logic              neg_reg, neg_next;
    logic [5:0]        iter_reg, iter_next;

    logic [CNT_W-1:0]  eff_n;
    logic [3:0]        divisor;
    logic signed [DATA_W:0] diff;
    logic [4:0]        r2;
    logic              ge;

    assign eff_n   = (count_reg > CNT_W'(EFF_MAX)) ? CNT_W'(EFF_MAX) : count_reg;
    assign divisor = 4'(eff_n - CNT_W'(1));
    assign diff    = {max_reg[DATA_W-1], max_reg} - {min_reg[DATA_W-1], min_reg};
    assign r2      = {rem_reg, quo_reg[DATA_W]};
    assign ge      = r2 >= {1'b0, divisor};

    always_comb
    begin
        state_next      = state_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        step_valid_next = step_valid_reg;
        idx_next        = idx_reg;
        marker_next     = marker_reg;
        tri_next        = tri_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        neg_next        = neg_reg;
        iter_next       = iter_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    tri_next = in_tri;
                    if (step_valid_reg || eff_n < CNT_W'(2))
                    begin
                        if (!step_valid_reg)
                        begin
                            step_next       = '0;
                            step_valid_next = 1'b1;
                        end
                        state_next  = ST_SWEEP;
                        idx_next    = '0;
                        marker_next = (eff_n == '0);
                    end
                    else
                    begin
                        neg_next   = diff[DATA_W];
                        quo_next   = diff[DATA_W] ? (DATA_W+1)'(-diff) : diff;
                        rem_next   = '0;
                        iter_next  = '0;
                        state_next = ST_STEP;
                    end
                end
            end
            ST_STEP:
            begin
                if (iter_reg == 6'(STEP_ITERS))
                begin
                    if (!neg_reg)
                        step_next = (quo_reg > (DATA_W+1)'(33'h0_7FFF_FFFF)) ?
                                    q_t'(32'h7FFF_FFFF) : q_t'(quo_reg[DATA_W-1:0]);
                    else
                        step_next = (quo_reg > (DATA_W+1)'(33'h0_8000_0000)) ?
                                    q_t'(32'h8000_0000) : q_t'(DATA_W'(-quo_reg));
                    step_valid_next = 1'b1;
                    state_next      = ST_SWEEP;
                    idx_next        = '0;
                    marker_next     = 1'b0;
                end
                else
                begin
                    rem_next  = ge ? 4'(r2 - {1'b0, divisor}) : r2[3:0];
                    quo_next  = {quo_reg[DATA_W-1:0], ge};
                    iter_next = iter_reg + 6'd1;
                end
            end
            ST_SWEEP:
            begin
                if (en)
                begin
                    if (marker_reg)
                        state_next = ST_IDLE;
                    else if ({1'b0, idx_reg} == 5'(eff_n - CNT_W'(1)))
                        marker_next = 1'b1;
                    else
                        idx_next = idx_reg + IDX_W'(1);
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (cfg_wen)
        begin
            unique case (cfg_index)
                CFG_LEVEL_MIN:
                begin
                    min_next        = cfg_wdata;
                    step_valid_next = 1'b0;
                end
                CFG_LEVEL_MAX:
                begin
                    max_next        = cfg_wdata;
                    step_valid_next = 1'b0;
                end
                CFG_LEVEL_COUNT:
                begin
                    count_next      = cfg_wdata[CNT_W-1:0];
                    step_valid_next = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            min_reg        <= '0;
            max_reg        <= q_t'(32'h0001_0000);
            count_reg      <= CNT_W'(10);
            step_reg       <= '0;
            step_valid_reg <= 1'b0;
            idx_reg        <= '0;
            marker_reg     <= 1'b0;
            iter_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            min_reg        <= min_next;
            max_reg        <= max_next;
            count_reg      <= count_next;
            step_reg       <= step_next;
            step_valid_reg <= step_valid_next;
            idx_reg        <= idx_next;
            marker_reg     <= marker_next;
            iter_reg       <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tri_reg <= tri_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign issue.valid  = (state_reg == ST_SWEEP);
    assign issue.marker = marker_reg;
    assign issue.idx    = idx_reg;
    assign tri_data     = tri_reg;
    assign level_min    = min_reg;
    assign step         = step_reg;

endmodule

// ===== sv/tie_cross.sv =====
// One edge crossing unit: sign test, pipelined fraction divider, interpolation.
// Depends on tie_pkg.
module tie_cross
    import tie_pkg::*;
(
    input  logic clk,
    input  logic en,
    input  q_t   level,
    input  q_t   vp,
    input  q_t   vq,
    input  q_t   xp,
    input  q_t   yp,
    input  q_t   xq,
    input  q_t   yq,
    output logic hit,
    output q_t   x,
    output q_t   y
);

    typedef struct packed {
        logic              hit;
        logic [DATA_W:0]   rem;
        logic [DATA_W:0]   den;
        logic [T_FRAC-1:0] q;
        q_t                xp;
        q_t                yp;
        logic [DATA_W:0]   dxm;
        logic              dxn;
        logic [DATA_W:0]   dym;
        logic              dyn;
    } div_t;

    div_t pipe_reg [DIV_STAGES+1];

    logic signed [DATA_W:0] dp, dq, dv, dx, dy;
    div_t a_next;

    assign dp = {vp[DATA_W-1], vp} - {level[DATA_W-1], level};
    assign dq = {vq[DATA_W-1], vq} - {level[DATA_W-1], level};
    assign dv = {vq[DATA_W-1], vq} - {vp[DATA_W-1], vp};
    assign dx = {xq[DATA_W-1], xq} - {xp[DATA_W-1], xp};
    assign dy = {yq[DATA_W-1], yq} - {yp[DATA_W-1], yp};

    always_comb
    begin
        a_next.hit = ((dp < 0) && (dq > 0)) || ((dp > 0) && (dq < 0));
        a_next.rem = dp[DATA_W] ? (DATA_W+1)'(-dp) : dp;
        a_next.den = dv[DATA_W] ? (DATA_W+1)'(-dv) : dv;
        a_next.q   = '0;
        a_next.xp  = xp;
        a_next.yp  = yp;
        a_next.dxm = dx[DATA_W] ? (DATA_W+1)'(-dx) : dx;
        a_next.dxn = dx[DATA_W];
        a_next.dym = dy[DATA_W] ? (DATA_W+1)'(-dy) : dy;
        a_next.dyn = dy[DATA_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            pipe_reg[0] <= a_next;
    end

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        div_t nxt;

        always_comb
        begin : p_step
            logic [DATA_W+1:0] r2;
            nxt = pipe_reg[g];
            for (int j = 0; j < DIV_STEPS; j++)
            begin
                r2 = {nxt.rem, 1'b0};
                if (r2 >= {1'b0, nxt.den})
                begin
                    nxt.rem = (DATA_W+1)'(r2 - {1'b0, nxt.den});
                    nxt.q   = {nxt.q[T_FRAC-2:0], 1'b1};
                end
                else
                begin
                    nxt.rem = r2[DATA_W:0];
                    nxt.q   = {nxt.q[T_FRAC-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
                pipe_reg[g+1] <= nxt;
        end
    end

    logic [T_FRAC+DATA_W:0] px_reg, py_reg;
    logic                   m_hit_reg, m_dxn_reg, m_dyn_reg;
    q_t                     m_xp_reg, m_yp_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg    <= pipe_reg[DIV_STAGES].q * pipe_reg[DIV_STAGES].dxm;
            py_reg    <= pipe_reg[DIV_STAGES].q * pipe_reg[DIV_STAGES].dym;
            m_hit_reg <= pipe_reg[DIV_STAGES].hit;
            m_dxn_reg <= pipe_reg[DIV_STAGES].dxn;
            m_dyn_reg <= pipe_reg[DIV_STAGES].dyn;
            m_xp_reg  <= pipe_reg[DIV_STAGES].xp;
            m_yp_reg  <= pipe_reg[DIV_STAGES].yp;
        end
    end

    logic [DATA_W:0] offx, offy, sumx, sumy;
    logic            hit_reg;
    q_t              x_reg, y_reg;

    assign offx = px_reg[T_FRAC+DATA_W:T_FRAC];
    assign offy = py_reg[T_FRAC+DATA_W:T_FRAC];
    assign sumx = {m_xp_reg[DATA_W-1], m_xp_reg} + (m_dxn_reg ? (DATA_W+1)'(-offx) : offx);
    assign sumy = {m_yp_reg[DATA_W-1], m_yp_reg} + (m_dyn_reg ? (DATA_W+1)'(-offy) : offy);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= m_hit_reg;
            x_reg   <= q_t'(sumx[DATA_W-1:0]);
            y_reg   <= q_t'(sumy[DATA_W-1:0]);
        end
    end

    assign hit = hit_reg;
    assign x   = x_reg;
    assign y   = y_reg;

endmodule

// ===== sv/tie_collect.sv =====
// Pairs the crossings of a level into a segment, holds one back to mark the last.
// Depends on tie_pkg.
module tie_collect
    import tie_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  issue_t           meta,
    input  logic [2:0]       hit,
    input  q_t               ex [3],
    input  q_t               ey [3],
    input  logic             m_tready,
    output logic             m_tvalid,
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tlast,
    output logic             en
);

    typedef struct packed {
        q_t               sx;
        q_t               sy;
        q_t               fx;
        q_t               fy;
        logic [IDX_W-1:0] idx;
    } seg_t;

    seg_t  new_seg, pend_reg, out_reg;
    logic  pend_valid_reg, out_valid_reg, last_reg;
    logic  two;

    assign en  = !out_valid_reg || m_tready;
    assign two = ($countones(hit) == 2);

    always_comb
    begin
        new_seg.idx = meta.idx;
        if (hit[0])
        begin
            new_seg.sx = ex[0];
            new_seg.sy = ey[0];
            new_seg.fx = hit[1] ? ex[1] : ex[2];
            new_seg.fy = hit[1] ? ey[1] : ey[2];
        end
        else
        begin
            new_seg.sx = ex[1];
            new_seg.sy = ey[1];
            new_seg.fx = ex[2];
            new_seg.fy = ey[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            if (meta.valid && meta.marker)
            begin
                out_valid_reg  <= pend_valid_reg;
                pend_valid_reg <= 1'b0;
            end
            else if (meta.valid && two)
            begin
                out_valid_reg  <= pend_valid_reg;
                pend_valid_reg <= 1'b1;
            end
            else
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg  <= pend_reg;
            last_reg <= meta.marker;
            if (meta.valid && !meta.marker && two)
                pend_reg <= new_seg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = OUT_W'({out_reg.idx, out_reg.fy, out_reg.fx, out_reg.sy, out_reg.sx});

endmodule

// ===== sv/triangle_isoline_extractor.sv =====
// Triangle isoline extractor: one triangle word in, one segment word per crossed level out.
// After a configuration write the first triangle first derives the level step in a
// bit-serial divider, if over one level is set. The level sequencer then issues n levels
// plus one end marker per triangle (n = level_count limited to 16), stalling with the
// output, and sets the rate; a level crosses a pipeline (level, edge test, 12 stages
// of 2-bit fraction division, interpolation, collection), and tlast marks the final
// segment of each triangle. A triangle with no segments produces no word.
// Depends on tie_pkg, tie_seq, tie_cross, tie_collect.
module triangle_isoline_extractor
    import tie_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wen,
    input  logic [1:0]        cfg_index,
    input  logic [DATA_W-1:0] cfg_wdata,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // a_x, a_y, b_x, b_y, c_x, c_y, a_value, b_value, c_value
    input  logic [TRI_W-1:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // start_x, start_y, end_x, end_y, level_index, zero fill
    output logic [OUT_W-1:0]  m_axis_tdata,
    output logic              m_axis_tlast
);

    issue_t              issue;
    logic [TRI_W-1:0]    tri_data;
    q_t                  level_min, step;
    logic                en;

    tie_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_tri    (s_axis_tdata),
        .en        (en),
        .issue     (issue),
        .tri_data  (tri_data),
        .level_min (level_min),
        .step      (step)
    );

    logic signed [DATA_W+5:0] lvl_wide;
    q_t                       lvl_sat;

    assign lvl_wide = (DATA_W+6)'(level_min)
                    + (DATA_W+6)'($signed({1'b0, issue.idx})) * (DATA_W+6)'(step);
    assign lvl_sat  = (lvl_wide > (DATA_W+6)'(32'sh7FFF_FFFF)) ? q_t'(32'h7FFF_FFFF) :
                      (lvl_wide < (DATA_W+6)'(32'sh8000_0000)) ? q_t'(32'h8000_0000) :
                      q_t'(lvl_wide[DATA_W-1:0]);

    issue_t           s1_meta_reg;
    q_t               s1_level_reg;
    logic [TRI_W-1:0] s1_tri_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_meta_reg <= '0;
        else if (en)
            s1_meta_reg <= issue;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_level_reg <= lvl_sat;
            s1_tri_reg   <= tri_data;
        end
    end

    q_t vx [3];
    q_t vy [3];
    q_t vv [3];

    for (genvar k = 0; k < 3; k++)
    begin : g_vtx
        assign vx[k] = s1_tri_reg[(2*k)*DATA_W +: DATA_W];
        assign vy[k] = s1_tri_reg[(2*k+1)*DATA_W +: DATA_W];
        assign vv[k] = s1_tri_reg[(6+k)*DATA_W +: DATA_W];
    end

    logic [2:0] hit;
    q_t         ex [3];
    q_t         ey [3];

    for (genvar e = 0; e < 3; e++)
    begin : g_edge
        tie_cross u_cross (
            .clk   (clk),
            .en    (en),
            .level (s1_level_reg),
            .vp    (vv[e]),
            .vq    (vv[(e+1)%3]),
            .xp    (vx[e]),
            .yp    (vy[e]),
            .xq    (vx[(e+1)%3]),
            .yq    (vy[(e+1)%3]),
            .hit   (hit[e]),
            .x     (ex[e]),
            .y     (ey[e])
        );
    end

    issue_t meta_reg [CROSS_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < CROSS_LAT; s++)
                meta_reg[s] <= '0;
        end
        else if (en)
        begin
            meta_reg[0] <= s1_meta_reg;
            for (int s = 1; s < CROSS_LAT; s++)
                meta_reg[s] <= meta_reg[s-1];
        end
    end

    tie_collect u_collect (
        .clk      (clk),
        .rst_n    (rst_n),
        .meta     (meta_reg[CROSS_LAT-1]),
        .hit      (hit),
        .ex       (ex),
        .ey       (ey),
        .m_tready (m_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tdata  (m_axis_tdata),
        .m_tlast  (m_axis_tlast),
        .en       (en)
    );

`ifndef SYNTHESIS
    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !issue.valid)
        else $error("triangle accepted while levels still issuing");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("sequencer did not leave idle after accepting a word");

    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(s1_meta_reg) && $stable(meta_reg[CROSS_LAT-1]))
        else $error("pipeline moved while stalled");
`endif

endmodule

// ===== bench/triangle_isoline_extractor_test.sv =====
// Self-checking bench for triangle_isoline_extractor: drives triangle words with bursty
// gaps, stalls the segment stream, predicts segments per level and compares each word.
// Depends on tie_pkg and the triangle_isoline_extractor RTL.
class segment_board;
    typedef struct packed {
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] ex;
        logic [31:0] ey;
        logic [3:0]  idx;
        logic        lst;
    } seg_t;

    seg_t pending[$];
    int errors;
    longint lvl_min, lvl_max;
    int unsigned lvl_count;
    longint step;
    bit step_ok;

    function new();
        lvl_min = 0;
        lvl_max = 65536;
        lvl_count = 10;
        step = 0;
        step_ok = 0;
        errors = 0;
    endfunction

    function longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function void note_write(int idx, logic [31:0] val);
        if (idx == 0)
            lvl_min = longint'(signed'(val));
        else if (idx == 1)
            lvl_max = longint'(signed'(val));
        else if (idx == 2)
            lvl_count = {27'b0, val[4:0]};
        else
            return;
        step_ok = 0;
    endfunction

    function int unsigned levels();
        return (lvl_count > 16) ? 16 : lvl_count;
    endfunction

    function bit edge_hit(longint xp, longint yp, longint vp, longint xq, longint yq,
                          longint vq, longint lv, output longint cx, output longint cy);
        longint dp, dq, t;
        dp = vp - lv;
        dq = vq - lv;
        if (!((dp < 0 && dq > 0) || (dp > 0 && dq < 0)))
            return 0;
        t = ((lv - vp) * (64'sd1 << 24)) / (vq - vp);
        cx = xp + (t * (xq - xp)) / (64'sd1 << 24);
        cy = yp + (t * (yq - yp)) / (64'sd1 << 24);
        return 1;
    endfunction

    function void note_triangle(logic [287:0] d);
        longint f[9];
        longint lv, x, y, px[2], py[2];
        int unsigned n;
        int hits, cnt;
        seg_t s;
        for (int k = 0; k < 9; k++)
            f[k] = longint'(signed'(d[k*32 +: 32]));
        if (!step_ok)
        begin
            n = levels();
            step = (n < 2) ? 0 : clamp32((lvl_max - lvl_min) / longint'(n - 1));
            step_ok = 1;
        end
        n = levels();
        cnt = 0;
        for (int i = 0; i < n; i++)
        begin
            lv = clamp32(lvl_min + i * step);
            hits = 0;
            for (int e = 0; e < 3; e++)
            begin
                bit h;
                int p, q;
                p = e;
                q = (e + 1) % 3;
                h = edge_hit(f[2*p], f[2*p+1], f[6+p], f[2*q], f[2*q+1], f[6+q], lv, x, y);
                if (h)
                begin
                    if (hits < 2)
                    begin
                        px[hits] = x;
                        py[hits] = y;
                    end
                    hits++;
                end
            end
            if (hits == 2)
            begin
                s.sx = 32'(px[0]);
                s.sy = 32'(py[0]);
                s.ex = 32'(px[1]);
                s.ey = 32'(py[1]);
                s.idx = 4'(i);
                s.lst = 0;
                pending = {pending, s};
                cnt++;
            end
        end
        if (cnt > 0)
            pending[pending.size()-1].lst = 1;
    endfunction

    function void check_segment(logic [135:0] d, logic lst);
        seg_t got, want;
        got = {d[31:0], d[63:32], d[95:64], d[127:96], d[131:128], lst};
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected segment %h", $time, got);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got !== want)
        begin
            $display("%0t: segment mismatch expected %h actual %h", $time, want, got);
            errors++;
        end
    endfunction
endclass

module triangle_isoline_extractor_test;
    import tie_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_wen = 0;
    logic [1:0] cfg_index = '0;
    logic [DATA_W-1:0] cfg_wdata = '0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [TRI_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic m_axis_tlast;

    segment_board board = new();
    longint cycles = 0;
    bit stall_on = 1;

    triangle_isoline_extractor dut (.*);

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 600000)
        begin
            $display("triangle_isoline_extractor test failed");
            $finish;
        end
        if (m_axis_tvalid && m_axis_tready)
            board.check_segment(m_axis_tdata, m_axis_tlast);
        if (s_axis_tvalid && s_axis_tready)
            board.note_triangle(s_axis_tdata);
    end

    // receiver stall pattern
    always @(negedge clk)
        m_axis_tready <= stall_on ? (($urandom_range(0, 7) < 5) || cycles[9]) : 1'b1;

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_wen <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_wen <= 0;
        board.note_write(idx, val);
    endtask

    task automatic drain();
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic send_triangle(logic [TRI_W-1:0] d, bit hold);
        s_axis_tdata <= d;
        s_axis_tvalid <= 1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        if (!hold)
            s_axis_tvalid <= 0;
    endtask

    function automatic logic [TRI_W-1:0] tri_word(int ax, int ay, int bx, int by, int cx,
                                                  int cy, int va, int vb, int vc);
        return {vc, vb, va, cy, cx, by, bx, ay, ax};
    endfunction

    function automatic logic [TRI_W-1:0] rand_tri(bit wild);
        logic [TRI_W-1:0] d;
        for (int k = 0; k < 9; k++)
            d[k*32 +: 32] = wild ? $urandom : (k < 6 ? $urandom_range(0, 20'hFFFFF) - 20'h80000
                                                       : $urandom_range(0, 20'h2FFFF) - 20'h8000);
        return d;
    endfunction

    task automatic random_phase(int n);
        int left, burst, gap;
        left = n;
        while (left > 0)
        begin
            burst = $urandom_range(1, 8);
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 30);
            while (burst > 0 && left > 0)
            begin
                send_triangle(rand_tri($urandom_range(0, 5) == 0),
                              (burst > 1 || gap == 0) && left > 1);
                burst--;
                left--;
            end
            repeat (gap) @(negedge clk);
        end
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n = 1;
        // directed: reset levels, flat, vertex on level, extremes
        send_triangle(tri_word(0, 0, 65536, 0, 0, 65536, 0, 65536, 32768), 1);
        send_triangle(tri_word(1, 2, 3, 4, 5, 6, 7000, 7000, 7000), 1);
        send_triangle(tri_word(0, 0, 65536, 0, 0, 65536, -100, 100000, 6554), 1);
        send_triangle(tri_word(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                               0, 0, 32'h80000000, 32'h7fffffff, 0), 0);
        drain();
        write_reg(CFG_LEVEL_MIN, 32'h80000000);
        write_reg(CFG_LEVEL_MAX, 32'h7fffffff);
        write_reg(CFG_LEVEL_COUNT, 16);
        send_triangle(tri_word(32'h80000000, 0, 32'h7fffffff, 32'h7fffffff, 0, 32'h80000000,
                               32'h80000000, 32'h7fffffff, 12345), 1);
        send_triangle(rand_tri(1), 0);
        drain();
        // step saturates: max below min with count 2
        write_reg(CFG_LEVEL_MIN, 32'h7fffffff);
        write_reg(CFG_LEVEL_MAX, 32'h80000000);
        write_reg(CFG_LEVEL_COUNT, 2);
        send_triangle(tri_word(0, 0, 100, 0, 0, 100, 32'h80000000, 32'h7fffffff, 0), 0);
        drain();
        write_reg(CFG_LEVEL_COUNT, 1);
        write_reg(CFG_LEVEL_MIN, 0);
        send_triangle(tri_word(0, 0, 65536, 0, 0, 65536, -5, 5, 5), 0);
        drain();
        write_reg(CFG_LEVEL_COUNT, 0);
        send_triangle(tri_word(0, 0, 65536, 0, 0, 65536, -5, 5, 5), 0);
        drain();
        write_reg(CFG_LEVEL_COUNT, 31);
        write_reg(2'd3, 32'hffffffff);
        send_triangle(tri_word(0, 0, 65536, 0, 0, 65536, -5, 5, 5), 0);
        drain();
        write_reg(CFG_LEVEL_MIN, 0);
        write_reg(CFG_LEVEL_MAX, 32'h20000);
        write_reg(CFG_LEVEL_COUNT, 10);
        random_phase(70);
        drain();
        write_reg(CFG_LEVEL_MIN, -32'sh8000);
        write_reg(CFG_LEVEL_MAX, 32'h28000);
        write_reg(CFG_LEVEL_COUNT, 16);
        random_phase(60);
        drain();
        stall_on = 0;
        write_reg(CFG_LEVEL_MIN, $urandom_range(0, 32'h10000) - 32'h8000);
        write_reg(CFG_LEVEL_MAX, $urandom_range(32'h10000, 32'h30000));
        write_reg(CFG_LEVEL_COUNT, $urandom_range(2, 16));
        random_phase(40);
        drain();
        stall_on = 1;
        write_reg(CFG_LEVEL_MIN, $urandom);
        write_reg(CFG_LEVEL_MAX, $urandom);
        write_reg(CFG_LEVEL_COUNT, $urandom_range(0, 31));
        random_phase(50);
        drain();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("triangle_isoline_extractor test passed");
        else
            $display("triangle_isoline_extractor test failed");
        $finish;
    end
endmodule
